// File: design/atto_pkg.sv
package atto_pkg;

   localparam int ADDR_W  = 6;
   localparam int VALUE_W = 32;
   localparam int LVL_W   = 3;
   localparam int ORDER_W = 2;

   localparam logic [LVL_W-1:0] LEVELS_RESET = 3'd4;

   // item kind
   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_WALK = 1'b1;

   // walk order codes; code 3 means nothing and is dropped
   typedef enum logic [ORDER_W-1:0] {
      ORDER_IN   = 2'd0,
      ORDER_PRE  = 2'd1,
      ORDER_POST = 2'd2
   } order_type;

   typedef struct packed {
      logic                      kind;
      logic [ADDR_W-1:0]         node_address;
      logic signed [VALUE_W-1:0] node_value;
      logic [ORDER_W-1:0]        walk_order;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] element_value;
      logic [ADDR_W-1:0]         visited_index;
      logic                      last_element;
   } rsp_type;

   // one visit issued by the walker
   typedef struct packed {
      logic [ADDR_W-1:0] index;
      logic              last;
   } step_type;

endpackage

// File: design/atto_walk.sv
// Iterative tree walker: one heap node per advance, no stack.
// h is the 1-based heap index, d its depth.
module atto_walk (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [atto_pkg::ORDER_W-1:0]  order,
   input  logic [atto_pkg::LVL_W-1:0]    levels,
   input  logic                          advance,
   output logic                          busy,
   output atto_pkg::step_type            step
);
   import atto_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_WALK = 2'b10
   } state_type;

   state_type          state_ff;
   state_type          state_in;
   logic [ADDR_W-1:0]  h_ff, h_in;
   logic [LVL_W-1:0]   d_ff, d_in;
   logic [ADDR_W-1:0]  count_ff, count_in;
   logic [ADDR_W-1:0]  last_ff, last_in;
   logic [ORDER_W-1:0] order_ff, order_in;
   logic [LVL_W-1:0]   lm1_ff, lm1_in;

   logic [LVL_W-1:0]   ones;
   logic               run;
   logic [ADDR_W:0]    h_wide;
   logic [LVL_W-1:0]   d_next;
   logic [ADDR_W:0]    n_full;
   logic [LVL_W-1:0]   lm1_start;
   logic               issue;

   assign busy       = (state_ff == ST_WALK);
   assign issue      = busy && advance;
   assign step.index = h_ff - ADDR_W'(1);
   assign step.last  = (count_ff == last_ff);

   assign lm1_start = levels - LVL_W'(1);
   assign n_full    = (ADDR_W+1)'(1) << levels;

   // successor of h in the stored order
   always_comb begin
      ones   = '0;
      run    = 1'b1;
      h_wide = '0;
      d_next = d_ff;
      for (int i = 0; i < ADDR_W; i++) begin
         if (run && h_ff[i]) begin
            ones = ones + LVL_W'(1);
         end else begin
            run = 1'b0;
         end
      end
      case (order_ff)
         ORDER_IN: begin
            if (d_ff != lm1_ff) begin
               // right child, then leftmost leaf below it
               h_wide = {h_ff, 1'b1} << LVL_W'(lm1_ff - d_ff - LVL_W'(1));
               d_next = lm1_ff;
            end else begin
               // climb past right-child links, then one more
               h_wide = {1'b0, h_ff} >> LVL_W'(ones + LVL_W'(1));
               d_next = d_ff - ones - LVL_W'(1);
            end
         end
         ORDER_PRE: begin
            if (d_ff != lm1_ff) begin
               h_wide = {h_ff, 1'b0};
               d_next = d_ff + LVL_W'(1);
            end else begin
               h_wide = ({1'b0, h_ff} >> ones) + (ADDR_W+1)'(1);
               d_next = d_ff - ones;
            end
         end
         ORDER_POST: begin
            if (!h_ff[0]) begin
               // left child: sibling, then its leftmost leaf
               h_wide = ({1'b0, h_ff} + (ADDR_W+1)'(1)) << LVL_W'(lm1_ff - d_ff);
               d_next = lm1_ff;
            end else begin
               h_wide = {1'b0, h_ff} >> 1;
               d_next = d_ff - LVL_W'(1);
            end
         end
         default: begin
            h_wide = {1'b0, h_ff};
            d_next = d_ff;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      h_in     = h_ff;
      d_in     = d_ff;
      count_in = count_ff;
      last_in  = last_ff;
      order_in = order_ff;
      lm1_in   = lm1_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_WALK;
               order_in = order;
               lm1_in   = lm1_start;
               count_in = '0;
               last_in  = ADDR_W'(n_full - (ADDR_W+1)'(2));
               if (order == ORDER_PRE) begin
                  h_in = ADDR_W'(1);
                  d_in = '0;
               end else begin
                  h_in = ADDR_W'((ADDR_W+1)'(1) << lm1_start);
                  d_in = lm1_start;
               end
            end
         end
         ST_WALK: begin
            if (issue) begin
               h_in     = h_wide[ADDR_W-1:0];
               d_in     = d_next;
               count_in = count_ff + ADDR_W'(1);
               if (step.last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      h_ff     <= h_in;
      d_ff     <= d_in;
      count_ff <= count_in;
      last_ff  <= last_in;
      order_ff <= order_in;
      lm1_ff   <= lm1_in;
   end

endmodule

// File: design/array_tree_traversal_order_top.sv
// Perfect binary tree held in a heap-ordered array (children of i at 2i+1, 2i+2).
//
// req channel (req_valid/req_stall/req_data): a load item writes one node value
// and gives no result; loads are taken one per cycle while no walk runs. A walk
// item emits every node of the active tree (2^levels - 1 nodes) in in-order,
// pre-order or post-order; walk order 3 is dropped. Loads to addresses past the
// store are dropped.
// rsp channel (rsp_valid/rsp_stall/rsp_data): one transfer per visited node,
// value plus array index, last_element set on the final node.
// csr channel (csr_valid/csr_ready/csr_data): writes levels; 0 counts as 1 and
// values above MAX_LEVELS count as MAX_LEVELS. Write only while idle.
//
// Timing: a walk item passes the walker state register, read stage and output
// register before its first result shows; then one node per cycle while rsp is
// not stalled. The walker issues one store read per cycle unless held, and
// req_stall is high while it walks. A stalled rsp backs up through the read
// stage into the walker, which holds. Reset: levels returns to 4, pipeline
// empties, store contents are unknown until written.
module array_tree_traversal_order_top #(
   parameter int MAX_LEVELS = 6
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  atto_pkg::req_type           req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output atto_pkg::rsp_type           rsp_data,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [atto_pkg::LVL_W-1:0]  csr_data
);
   import atto_pkg::*;

   localparam int STORE_DEPTH = 2**MAX_LEVELS - 1;
   localparam int SA_W        = MAX_LEVELS;

   // levels register and its clamped view
   logic [LVL_W-1:0] levels_ff;
   logic [LVL_W-1:0] levels_eff;

   // store
   logic signed [VALUE_W-1:0] store_mem [STORE_DEPTH];

   // read stage (s1) and output stage
   logic                      s1_valid_ff;
   logic signed [VALUE_W-1:0] rd_data_ff;
   step_type                  s1_step_ff;
   logic                      rsp_valid_ff;
   rsp_type                   rsp_data_ff;

   logic     req_xfer;
   logic     load_en;
   logic     walk_start;
   logic     out_load;
   logic     advance;
   logic     issue;
   logic     busy;
   step_type step;

   always_comb begin
      levels_eff = levels_ff;
      if (levels_ff == '0) begin
         levels_eff = LVL_W'(1);
      end else if (levels_ff > LVL_W'(MAX_LEVELS)) begin
         levels_eff = LVL_W'(MAX_LEVELS);
      end
   end

   assign req_stall = busy;
   assign csr_ready = !busy;
   assign req_xfer  = req_valid && !req_stall;
   assign load_en   = req_xfer && (req_data.kind == KIND_LOAD) &&
                      ({1'b0, req_data.node_address} < (ADDR_W+1)'(STORE_DEPTH));
   // walk order 3 never starts the walker
   assign walk_start = req_xfer && (req_data.kind == KIND_WALK) &&
                       (req_data.walk_order == ORDER_IN  ||
                        req_data.walk_order == ORDER_PRE ||
                        req_data.walk_order == ORDER_POST);

   // output register free this cycle, read stage empties into it
   assign out_load = !rsp_valid_ff || !rsp_stall;
   assign advance  = !s1_valid_ff || out_load;
   assign issue    = busy && advance;

   atto_walk u_walk (
      .clock   (clock),
      .reset   (reset),
      .start   (walk_start),
      .order   (req_data.walk_order),
      .levels  (levels_eff),
      .advance (advance),
      .busy    (busy),
      .step    (step)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         levels_ff <= LEVELS_RESET;
      end else if (csr_valid && csr_ready) begin
         levels_ff <= csr_data;
      end
   end

   // one write port (loads), one registered read port (walker)
   always_ff @(posedge clock) begin
      if (load_en) begin
         store_mem[req_data.node_address[SA_W-1:0]] <= req_data.node_value;
      end
      if (issue) begin
         rd_data_ff <= store_mem[step.index[SA_W-1:0]];
         s1_step_ff <= step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (issue) begin
            s1_valid_ff <= 1'b1;
         end else if (out_load) begin
            s1_valid_ff <= 1'b0;
         end
         if (out_load) begin
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_load && s1_valid_ff) begin
         rsp_data_ff.element_value <= rd_data_ff;
         rsp_data_ff.visited_index <= s1_step_ff.index;
         rsp_data_ff.last_element  <= s1_step_ff.last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a held read stage must not be overwritten by a new issue
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_load) |-> !issue)
      else $error("walker issued into a full read stage");

   // the walker only goes idle right after issuing its final node
   a_walk_end: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> $past(issue && step.last))
      else $error("walk ended without its last node");

   // a new result only ever comes from the read stage
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(s1_valid_ff))
      else $error("result appeared without a read behind it");

endmodule
